// File: src/ppm_pkg.sv
package ppm_pkg;

   // Number format
   localparam int CW      = 32;               // coordinate width
   localparam int FB      = 16;               // fraction bits
   localparam int FIELD_W = 32;               // port field width
   localparam int COEF_W  = 32;               // coefficient lane width
   localparam int CFG_W   = 64;               // widest register
   localparam int IDX_W   = 3;

   // Derived datapath widths
   localparam int PROD_W = CW + COEF_W;
   localparam int NUM_W  = PROD_W + 2;
   localparam int REM_W  = NUM_W + CW + FB + 1;
   localparam int QS_W   = CW + 1 + FB;

   // Queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Register indexes
   localparam logic [IDX_W-1:0] REG_X_ROW   = 3'd0;
   localparam logic [IDX_W-1:0] REG_Y_ROW   = 3'd1;
   localparam logic [IDX_W-1:0] REG_WEIGHT  = 3'd2;
   localparam logic [IDX_W-1:0] REG_OFFSET  = 3'd3;
   localparam logic [IDX_W-1:0] REG_W_OFFS  = 3'd4;
   localparam logic [IDX_W-1:0] REG_RMODE   = 3'd5;

   // Rounding modes
   localparam logic [1:0] MODE_FRAC  = 2'd0;
   localparam logic [1:0] MODE_ROUND = 2'd1;
   localparam logic [1:0] MODE_TRUNC = 2'd2;

   // Status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_SAT   = 2'd1;
   localparam logic [1:0] ST_WZERO = 2'd2;

   typedef struct packed {
      logic signed [FIELD_W-1:0] in_x;
      logic signed [FIELD_W-1:0] in_y;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] out_x;
      logic signed [FIELD_W-1:0] out_y;
      logic [1:0]                status;
   } rsp_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] m11, m21, m12, m22, m13, m23, m31, m32, m33;
      logic [1:0]               mode;
   } cfg_type;

   // Classified item, ready for division
   typedef struct packed {
      logic [REM_W-1:0] nmag_x, nmag_y, dmag;
      logic             nneg_x, nneg_y, nzero_x, nzero_y;
      logic             dneg, wzero;
      logic [1:0]       mode;
   } entry_type;

   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [CW-1:0]    q;
      logic             ovf, nneg, nzero;
   } lane_type;

   typedef struct packed {
      logic             valid;
      lane_type         lx, ly;
      logic [REM_W-1:0] dmag;
      logic             dneg, wzero;
      logic [1:0]       mode;
   } stage_type;

   typedef struct packed {
      logic [CW-1:0] value;
      logic          sat;
   } axis_type;

   // One restoring quotient bit
   function automatic lane_type div_step(lane_type l, logic [REM_W-1:0] dmag, int unsigned bpos);
      lane_type         r;
      logic [REM_W-1:0] sh;
      r  = l;
      sh = dmag << bpos;
      if (l.rem >= sh) begin
         r.rem     = l.rem - sh;
         r.q[bpos] = 1'b1;
      end
      return r;
   endfunction

   function automatic logic [CW-1:0] sat_end(logic negative);
      return negative ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
   endfunction

   // Round, sign and clamp one axis
   function automatic axis_type finish(lane_type l, logic [REM_W-1:0] dmag, logic dneg,
                                       logic [1:0] mode, logic wzero);
      axis_type      r;
      logic [CW:0]   qr;
      logic [QS_W-1:0] qs, lim;
      logic          up, negative;
      up  = (mode == MODE_FRAC || mode == MODE_ROUND) && ({l.rem, 1'b0} >= {1'b0, dmag});
      qr  = {1'b0, l.q} + {{CW{1'b0}}, up};
      qs  = (mode != MODE_FRAC) ? (QS_W'(qr) << FB) : QS_W'(qr);
      lim = QS_W'(1) << (CW - 1);
      negative = (l.nneg != dneg) && (qs != '0 || l.ovf);
      if (wzero) begin
         r.value = l.nzero ? '0 : sat_end(l.nneg);
         r.sat   = 1'b0;
      end else begin
         r.sat   = l.ovf || (!negative && qs >= lim) || (negative && qs > lim);
         r.value = r.sat ? sat_end(negative) : (negative ? -qs[CW-1:0] : qs[CW-1:0]);
      end
      return r;
   endfunction

endpackage

// File: src/ppm_front.sv
module ppm_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  ppm_pkg::req_type  in_item,
   input  ppm_pkg::cfg_type  cfg,
   output logic              a_busy,
   output logic              out_valid,
   output ppm_pkg::entry_type out_entry
);
   import ppm_pkg::*;

   logic signed [CW-1:0]     x_s, y_s;
   logic signed [PROD_W-1:0] pxa_ff, pya_ff, pxb_ff, pyb_ff, pxw_ff, pyw_ff;
   logic signed [COEF_W-1:0] m31_ff, m32_ff, m33_ff;
   logic                     affine_ff, a_valid_ff, b_valid_ff;
   logic [1:0]               mode_ff;
   logic signed [NUM_W-1:0]  nx, ny, nw;
   logic [NUM_W-1:0]         magx, magy, magw;
   entry_type                entry_in, entry_ff;

   assign x_s = in_item.in_x[CW-1:0];
   assign y_s = in_item.in_y[CW-1:0];

   // Stage A: products
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= in_valid;
      end
      pxa_ff    <= PROD_W'(x_s) * PROD_W'(cfg.m11);
      pya_ff    <= PROD_W'(y_s) * PROD_W'(cfg.m21);
      pxb_ff    <= PROD_W'(x_s) * PROD_W'(cfg.m12);
      pyb_ff    <= PROD_W'(y_s) * PROD_W'(cfg.m22);
      pxw_ff    <= PROD_W'(x_s) * PROD_W'(cfg.m13);
      pyw_ff    <= PROD_W'(y_s) * PROD_W'(cfg.m23);
      m31_ff    <= cfg.m31;
      m32_ff    <= cfg.m32;
      m33_ff    <= cfg.m33;
      mode_ff   <= cfg.mode;
      affine_ff <= (cfg.m13 == '0) && (cfg.m23 == '0);
   end

   // Stage B: sums, signs and divisor set-up
   always_comb begin
      nx   = NUM_W'(pxa_ff) + NUM_W'(pya_ff) + (NUM_W'(m31_ff) <<< FB);
      ny   = NUM_W'(pxb_ff) + NUM_W'(pyb_ff) + (NUM_W'(m32_ff) <<< FB);
      nw   = NUM_W'(pxw_ff) + NUM_W'(pyw_ff) + (NUM_W'(m33_ff) <<< FB);
      magx = nx[NUM_W-1] ? NUM_W'(-nx) : NUM_W'(nx);
      magy = ny[NUM_W-1] ? NUM_W'(-ny) : NUM_W'(ny);
      magw = nw[NUM_W-1] ? NUM_W'(-nw) : NUM_W'(nw);
      entry_in.nneg_x  = nx[NUM_W-1];
      entry_in.nneg_y  = ny[NUM_W-1];
      entry_in.nzero_x = (nx == '0);
      entry_in.nzero_y = (ny == '0);
      entry_in.mode    = mode_ff;
      entry_in.wzero   = !affine_ff && (nw == '0);
      entry_in.dneg    = !affine_ff && nw[NUM_W-1];
      if (!affine_ff && mode_ff == MODE_FRAC) begin
         entry_in.nmag_x = REM_W'(magx) << FB;
         entry_in.nmag_y = REM_W'(magy) << FB;
      end else begin
         entry_in.nmag_x = REM_W'(magx);
         entry_in.nmag_y = REM_W'(magy);
      end
      if (!affine_ff) begin
         entry_in.dmag = REM_W'(magw);
      end else if (mode_ff == MODE_FRAC) begin
         entry_in.dmag = REM_W'(1) << FB;
      end else begin
         entry_in.dmag = REM_W'(1) << (2 * FB);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      entry_ff <= entry_in;
   end

   assign a_busy    = a_valid_ff;
   assign out_valid = b_valid_ff;
   assign out_entry = entry_ff;

endmodule

// File: src/ppm_queue.sv
module ppm_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  ppm_pkg::entry_type         push_entry,
   input  logic                       pop,
   output logic                       not_empty,
   output ppm_pkg::entry_type         head,
   output logic [ppm_pkg::QCNT_W-1:0] count
);
   import ppm_pkg::*;

   entry_type          slot_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;

   // Advance pointers and occupancy
   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_entry;
      end
   end

   assign head      = slot_ff[rd_ff];
   assign not_empty = (cnt_ff != '0);
   assign count     = cnt_ff;

endmodule

// File: src/ppm_back.sv
module ppm_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  ppm_pkg::entry_type in_entry,
   output logic               in_take,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output ppm_pkg::rsp_type   rsp_item
);
   import ppm_pkg::*;

   stage_type st_ff [CW+1];
   stage_type st0_in;
   logic      adv, out_valid_ff;
   axis_type  ax, ay;
   rsp_type   rsp_in, rsp_ff;

   // Whole pipeline moves unless a result waits untaken
   assign adv     = !out_valid_ff || rsp_pop;
   assign in_take = adv && in_valid;

   // Stage 0: load and test for quotient overflow
   always_comb begin
      st0_in.valid    = in_valid;
      st0_in.dmag     = in_entry.dmag;
      st0_in.dneg     = in_entry.dneg;
      st0_in.wzero    = in_entry.wzero;
      st0_in.mode     = in_entry.mode;
      st0_in.lx.rem   = in_entry.nmag_x;
      st0_in.lx.q     = '0;
      st0_in.lx.ovf   = in_entry.nmag_x >= (in_entry.dmag << CW);
      st0_in.lx.nneg  = in_entry.nneg_x;
      st0_in.lx.nzero = in_entry.nzero_x;
      st0_in.ly.rem   = in_entry.nmag_y;
      st0_in.ly.q     = '0;
      st0_in.ly.ovf   = in_entry.nmag_y >= (in_entry.dmag << CW);
      st0_in.ly.nneg  = in_entry.nneg_y;
      st0_in.ly.nzero = in_entry.nzero_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff[0].valid <= 1'b0;
      end else if (adv) begin
         st_ff[0] <= st0_in;
      end
   end

   // One quotient bit per stage, most significant first
   for (genvar k = 1; k <= CW; k++) begin : g_div
      stage_type s_in;
      always_comb begin
         s_in    = st_ff[k-1];
         s_in.lx = div_step(st_ff[k-1].lx, st_ff[k-1].dmag, CW - k);
         s_in.ly = div_step(st_ff[k-1].ly, st_ff[k-1].dmag, CW - k);
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[k].valid <= 1'b0;
         end else if (adv) begin
            st_ff[k] <= s_in;
         end
      end
   end

   // Round, clamp and form status
   always_comb begin
      ax = finish(st_ff[CW].lx, st_ff[CW].dmag, st_ff[CW].dneg, st_ff[CW].mode,
                  st_ff[CW].wzero);
      ay = finish(st_ff[CW].ly, st_ff[CW].dmag, st_ff[CW].dneg, st_ff[CW].mode,
                  st_ff[CW].wzero);
      rsp_in.out_x = FIELD_W'(ax.value);
      rsp_in.out_y = FIELD_W'(ay.value);
      if (st_ff[CW].wzero) begin
         rsp_in.status = ST_WZERO;
      end else if (ax.sat || ay.sat) begin
         rsp_in.status = ST_SAT;
      end else begin
         rsp_in.status = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= st_ff[CW].valid;
      end
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// File: src/projective_point_map_unit.sv
// Channel   Direction  Handshake            Payload
// req_      in         push / full          req_type  (in_x, in_y)
// rsp_      out        pop / empty          rsp_type  (out_x, out_y, status)
// csr_      in         write, index, data   64-bit register data
//
// One item per cycle while rsp_pop keeps up; items cross two front stages
// for products and sums, a one-deep pass through the queue, CW + 1 divider
// stages and the result register. The divider pipeline sets the latency.
// Reset is synchronous and loads the identity matrix with fractional mode.
// A stalled result freezes the divider; the front keeps filling the queue
// and full rises once the queue and front stages could hold no more.
module projective_point_map_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   input  ppm_pkg::req_type            req_item,
   output logic                        req_full,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output ppm_pkg::rsp_type            rsp_item,
   input  logic                        csr_write,
   input  logic [ppm_pkg::IDX_W-1:0]   csr_index,
   input  logic [ppm_pkg::CFG_W-1:0]   csr_data
);
   import ppm_pkg::*;

   cfg_type           cfg_ff, cfg_in;
   logic              accept, a_busy, f_valid, q_take, q_not_empty;
   entry_type         f_entry, q_head;
   logic [QCNT_W-1:0] q_count;
   logic [QCNT_W:0]   pending;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_X_ROW: begin
               cfg_in.m11 = csr_data[31:0];
               cfg_in.m21 = csr_data[63:32];
            end
            REG_Y_ROW: begin
               cfg_in.m12 = csr_data[31:0];
               cfg_in.m22 = csr_data[63:32];
            end
            REG_WEIGHT: begin
               cfg_in.m13 = csr_data[31:0];
               cfg_in.m23 = csr_data[63:32];
            end
            REG_OFFSET: begin
               cfg_in.m31 = csr_data[31:0];
               cfg_in.m32 = csr_data[63:32];
            end
            REG_W_OFFS: cfg_in.m33  = csr_data[31:0];
            REG_RMODE:  cfg_in.mode = csr_data[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff      <= '0;
         cfg_ff.m11  <= COEF_W'(64'd1 << FB);
         cfg_ff.m22  <= COEF_W'(64'd1 << FB);
         cfg_ff.m33  <= COEF_W'(64'd1 << FB);
         cfg_ff.mode <= MODE_FRAC;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Hold off input while queue plus front stages could overflow
   assign pending  = {1'b0, q_count} + (QCNT_W+1)'(a_busy) + (QCNT_W+1)'(f_valid);
   assign req_full = pending >= (QCNT_W+1)'(QDEPTH);
   assign accept   = req_push && !req_full;

   ppm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_item   (req_item),
      .cfg       (cfg_ff),
      .a_busy    (a_busy),
      .out_valid (f_valid),
      .out_entry (f_entry)
   );

   ppm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (f_valid),
      .push_entry (f_entry),
      .pop        (q_take),
      .not_empty  (q_not_empty),
      .head       (q_head),
      .count      (q_count)
   );

   ppm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_not_empty),
      .in_entry  (q_head),
      .in_take   (q_take),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule

// File: tb/tb_projective_point_map_unit.sv
module tb_projective_point_map_unit;
   import ppm_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_WAIT  = CW + 12;

   logic             clock;
   logic             reset;
   logic             req_push;
   req_type          req_item;
   logic             req_full;
   logic             rsp_empty;
   logic             rsp_pop = 1'b0;
   rsp_type          rsp_item;
   logic             csr_write;
   logic [IDX_W-1:0] csr_index;
   logic [CFG_W-1:0] csr_data;

   projective_point_map_unit dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_item(req_item), .req_full(req_full),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_item(rsp_item),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   // Shadow copy of the matrix registers
   logic [63:0] sh_x_row, sh_y_row, sh_weight, sh_offset;
   logic [31:0] sh_w_offs;
   logic [1:0]  sh_mode;

   rsp_type     mapped_q[$];
   int          mismatches;
   int          points_sent;
   int          points_checked;
   int          wzero_seen;
   int          sat_seen;
   int          cycles = 0;
   logic        gap_enable;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Limit the run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic signed [127:0] sx32(logic [31:0] v);
      return {{96{v[31]}}, v};
   endfunction

   // Divide, round and clamp one axis
   function automatic void map_axis(input logic signed [127:0] num,
                                    input logic signed [127:0] wgt,
                                    input logic affine, input logic [1:0] mode,
                                    output logic [31:0] value, output logic sat);
      logic        nneg, dneg, negative;
      logic [127:0] nmag, dmag, q, rem, lim;
      nneg = num[127];
      nmag = nneg ? -num : num;
      dneg = 1'b0;
      if (affine) begin
         dmag = 128'd1 << ((mode == MODE_FRAC) ? FB : 2 * FB);
      end else begin
         dneg = wgt[127];
         dmag = dneg ? -wgt : wgt;
         if (mode == MODE_FRAC) nmag = nmag << FB;
      end
      q   = nmag / dmag;
      rem = nmag % dmag;
      if (mode < MODE_TRUNC && (rem << 1) >= dmag) q = q + 1;
      if (mode != MODE_FRAC) q = q << FB;
      negative = (nneg != dneg) && (q != 0);
      lim = 128'd1 << (CW - 1);
      sat = 1'b0;
      if (!negative && q >= lim) begin
         value = 32'h7fff_ffff; sat = 1'b1;
      end else if (negative && q > lim) begin
         value = 32'h8000_0000; sat = 1'b1;
      end else begin
         value = negative ? -q[31:0] : q[31:0];
      end
   endfunction

   function automatic rsp_type map_point(req_type p);
      rsp_type r;
      logic signed [127:0] x, y, nx, ny, w;
      logic affine, sx, sy;
      logic [31:0] vx, vy;
      x  = sx32(p.in_x);
      y  = sx32(p.in_y);
      nx = x * sx32(sh_x_row[31:0]) + y * sx32(sh_x_row[63:32])
           + (sx32(sh_offset[31:0]) <<< FB);
      ny = x * sx32(sh_y_row[31:0]) + y * sx32(sh_y_row[63:32])
           + (sx32(sh_offset[63:32]) <<< FB);
      w  = x * sx32(sh_weight[31:0]) + y * sx32(sh_weight[63:32])
           + (sx32(sh_w_offs) <<< FB);
      affine = (sh_weight == 64'd0);
      if (!affine && w == 0) begin
         r.out_x  = (nx == 0) ? '0 : (nx[127] ? 32'h8000_0000 : 32'h7fff_ffff);
         r.out_y  = (ny == 0) ? '0 : (ny[127] ? 32'h8000_0000 : 32'h7fff_ffff);
         r.status = ST_WZERO;
      end else begin
         map_axis(nx, w, affine, sh_mode, vx, sx);
         map_axis(ny, w, affine, sh_mode, vy, sy);
         r.out_x  = vx;
         r.out_y  = vy;
         r.status = (sx || sy) ? ST_SAT : ST_OK;
      end
      return r;
   endfunction

   // Check each popped item against the oldest prediction
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (mapped_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item %p", rsp_item);
         end else begin
            e = mapped_q.pop_front();
            points_checked++;
            if (e.status == ST_WZERO) wzero_seen++;
            if (e.status == ST_SAT) sat_seen++;
            if (rsp_item.out_x !== e.out_x || rsp_item.out_y !== e.out_y ||
                rsp_item.status !== e.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected x=%h y=%h st=%0d got x=%h y=%h st=%0d",
                           e.out_x, e.out_y, e.status,
                           rsp_item.out_x, rsp_item.out_y, rsp_item.status);
            end
         end
      end
   end

   // Receiver stalls on its own slowly changing pattern
   always @(posedge clock) begin
      int phase;
      phase = (cycles / 97) % 4;
      case (phase)
         0: rsp_pop <= 1'b1;
         1: rsp_pop <= ($urandom_range(0, 1) == 0);
         2: rsp_pop <= ($urandom_range(0, 9) == 0);
         default: rsp_pop <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // Send one point and record its prediction
   task automatic send_point(logic [31:0] x, logic [31:0] y);
      req_type p;
      p.in_x = x;
      p.in_y = y;
      req_push <= 1'b1;
      req_item <= p;
      do @(posedge clock); while (req_full);
      mapped_q.push_back(map_point(p));
      points_sent++;
      if (gap_enable && $urandom_range(0, 7) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain;
      req_push <= 1'b0;
      while (mapped_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(logic [IDX_W-1:0] idx, logic [63:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         REG_X_ROW:  sh_x_row  = val;
         REG_Y_ROW:  sh_y_row  = val;
         REG_WEIGHT: sh_weight = val;
         REG_OFFSET: sh_offset = val;
         REG_W_OFFS: sh_w_offs = val[31:0];
         REG_RMODE:  sh_mode   = val[1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_coeff();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'(int'($urandom_range(0, 262144)) - 131072);
         2: return '0;
         3: return 32'h0001_0000;
         4: return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
         default: return 32'(int'($urandom_range(0, 4096)) - 2048);
      endcase
   endfunction

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 4))
         0, 1: return $urandom();
         2: return 32'(int'($urandom_range(0, 2097152)) - 1048576);
         3: return 32'(int'($urandom_range(0, 256)) - 128);
         default: return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
      endcase
   endfunction

   // Extremes and small values of the coordinates through the reset matrix
   task automatic test_reset_identity;
      send_point(32'h0000_0000, 32'h0000_0000);
      send_point(32'h7fff_ffff, 32'h8000_0000);
      send_point(32'h8000_0000, 32'h7fff_ffff);
      send_point(32'hffff_ffff, 32'h0001_8000);
      send_point(32'h0000_8000, 32'hffff_8000);
      drain();
   endtask

   // Every rounding mode, halves of an LSB and saturation on an affine matrix
   task automatic test_affine_modes;
      write_reg(REG_X_ROW, {32'h0000_8000, 32'h0000_8000});
      write_reg(REG_Y_ROW, {32'h7fff_ffff, 32'h8000_0000});
      write_reg(REG_OFFSET, {32'hffff_8000, 32'h0000_8000});
      for (int m = 0; m < 4; m++) begin
         write_reg(REG_RMODE, 64'(m));
         send_point(32'h0000_0001, 32'h0000_0000);
         send_point(32'hffff_ffff, 32'h0000_0000);
         send_point(32'h0001_8000, 32'hfffe_8000);
         send_point(32'h7fff_ffff, 32'h7fff_ffff);
         drain();
      end
   endtask

   // Projective divide and a weight of zero
   task automatic test_weight_zero;
      write_reg(REG_RMODE, {62'd0, MODE_FRAC});
      write_reg(REG_WEIGHT, {32'h0001_0000, 32'h0000_0000});
      write_reg(REG_W_OFFS, 64'd0);
      send_point(32'h0003_0000, 32'h0000_0000);
      send_point(32'h0000_0000, 32'h0000_0000);
      send_point(32'hfffd_0000, 32'h0000_0000);
      drain();
      write_reg(REG_W_OFFS, 64'h0000_0000_8000_0000);
      send_point(32'h0002_0000, 32'h0001_0000);
      drain();
      write_reg(REG_W_OFFS, 64'h0000_0000_7fff_ffff);
      send_point(32'h8000_0000, 32'h7fff_ffff);
      drain();
   endtask

   // Random matrices in phases, random points in bursts
   task automatic test_random_points;
      int n;
      gap_enable = 1'b1;
      for (int ph = 0; ph < 35; ph++) begin
         write_reg(REG_X_ROW, {pick_coeff(), pick_coeff()});
         write_reg(REG_Y_ROW, {pick_coeff(), pick_coeff()});
         write_reg(REG_WEIGHT, ($urandom_range(0, 2) == 0) ? 64'd0 :
                               {pick_coeff(), pick_coeff()});
         write_reg(REG_OFFSET, {pick_coeff(), pick_coeff()});
         write_reg(REG_W_OFFS, {32'd0, pick_coeff()});
         write_reg(REG_RMODE, 64'($urandom_range(0, 3)));
         n = $urandom_range(30, 70);
         for (int i = 0; i < n; i++) begin
            if (i == n / 2 && ph == 7) begin
               // hold off until everything in flight is out
               req_push <= 1'b0;
               while (mapped_q.size() != 0) @(posedge clock);
            end
            if ($urandom_range(0, 15) == 0)
               send_point(32'h0000_0000, pick_coord());
            else
               send_point(pick_coord(), pick_coord());
         end
         drain();
      end
      gap_enable = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_item = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      mismatches = 0;
      points_sent = 0;
      points_checked = 0;
      wzero_seen = 0;
      sat_seen = 0;
      gap_enable = 1'b0;
      sh_x_row  = 64'h0000_0000_0001_0000;
      sh_y_row  = 64'h0001_0000_0000_0000;
      sh_weight = 64'd0;
      sh_offset = 64'd0;
      sh_w_offs = 32'h0001_0000;
      sh_mode   = MODE_FRAC;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_identity();
      test_affine_modes();
      test_weight_zero();
      test_random_points();

      $display("mapped %0d points, checked %0d, %0d saturated, %0d with zero weight",
               points_sent, points_checked, sat_seen, wzero_seen);
      $display("affine and projective matrices, all four mode codes, bursty traffic");
      if (mismatches == 0 && mapped_q.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: projective_point_map_unit.f
src/ppm_pkg.sv
src/ppm_front.sv
src/ppm_queue.sv
src/ppm_back.sv
src/projective_point_map_unit.sv
tb/tb_projective_point_map_unit.sv
